// ----- sv/wfpd_pkg.sv -----
// Shared types, register indexes and reset values for the wall-follow PD drive.
package wfpd_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_PROP_GAIN       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DERIV_GAIN      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_DISTANCE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_DUTY       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_DUTY_MAX        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_DUTY_MIN        = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_WALL_THRESHOLD  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_TURN_DUTY       = 3'd7;

   // Register reset values
   localparam logic [7:0] RST_PROP_GAIN       = 8'd64;
   localparam logic [7:0] RST_DERIV_GAIN      = 8'd32;
   localparam logic [7:0] RST_TARGET_DISTANCE = 8'd110;
   localparam logic [7:0] RST_BASE_DUTY       = 8'd90;
   localparam logic [7:0] RST_DUTY_MAX        = 8'd170;
   localparam logic [7:0] RST_DUTY_MIN        = 8'd20;
   localparam logic [7:0] RST_WALL_THRESHOLD  = 8'd65;
   localparam logic [7:0] RST_TURN_DUTY       = 8'd40;

   // Opcodes of an input item
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_STOP = 1'b1;

   localparam logic [7:0] SYNC_BYTE   = 8'h00;
   localparam logic [8:0] TURN_MARGIN = 9'd10;

   localparam int unsigned ERR_W = 11;

   typedef enum logic [1:0] {
      PH_SYNC  = 2'd0,
      PH_FRONT = 2'd1,
      PH_REAR  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] prop_gain;
      logic [7:0] deriv_gain;
      logic [7:0] target_distance;
      logic [7:0] base_duty;
      logic [7:0] duty_max;
      logic [7:0] duty_min;
      logic [7:0] wall_threshold;
      logic [7:0] turn_duty;
   } cfg_type;

endpackage

// ----- sv/wfpd_side.sv -----
// PD correction, base offset and duty clamp for one motor side.
module wfpd_side (
   input  logic signed [wfpd_pkg::ERR_W-1:0] err,
   input  logic signed [wfpd_pkg::ERR_W-1:0] err_prev,
   input  wfpd_pkg::cfg_type                 cfg,
   output logic        [7:0]                 duty
);
   import wfpd_pkg::*;

   logic signed [ERR_W:0]   diff;
   logic signed [8:0]       kp;
   logic signed [8:0]       kd;
   logic signed [19:0]      p_prod;
   logic signed [20:0]      d_prod;
   logic signed [14:0]      p_term;
   logic signed [14:0]      d_term;
   logic signed [16:0]      u_sum;
   logic signed [16:0]      lim_hi;
   logic signed [16:0]      lim_lo;

   assign kp   = $signed({1'b0, cfg.prop_gain});
   assign kd   = $signed({1'b0, cfg.deriv_gain});
   assign diff = {err[ERR_W-1], err} - {err_prev[ERR_W-1], err_prev};

   assign p_prod = err * kp;
   assign d_prod = diff * kd;

   // Gain 2*kp/64 collapses to a floor shift by 5; derivative shifts by 6
   assign p_term = p_prod[19:5];
   assign d_term = d_prod[20:6];

   assign u_sum = {{2{p_term[14]}}, p_term} + {{2{d_term[14]}}, d_term}
                + $signed({9'd0, cfg.base_duty});

   assign lim_hi = $signed({9'd0, cfg.duty_max});
   assign lim_lo = $signed({9'd0, cfg.duty_min});

   // Upper limit wins when the limits cross
   always_comb begin
      if (u_sum > lim_hi) begin
         duty = cfg.duty_max;
      end else if (u_sum < lim_lo) begin
         duty = cfg.duty_min;
      end else begin
         duty = u_sum[7:0];
      end
   end

endmodule

// ----- sv/wall_follow_pd_drive.sv -----
// Top level of the wall-follow PD drive: framing, history, registers and result stage.
//
//   channel  ports                                 direction  transfer when
//   req      req_valid req_stall req_opcode         in         req_valid & !req_stall
//            req_rx_byte
//   rsp      rsp_valid rsp_stall rsp_left_duty      out        rsp_valid & !rsp_stall
//            rsp_right_duty rsp_left_forward
//            rsp_right_forward rsp_wall_seen
//   csr      csr_we csr_index csr_wdata             in         csr_we
//
// One item per cycle while no held result stalls the input. An item is registered
// in the input register; the framing and PD datapath between that register and
// the result register are combinational, so a result is loaded into the result
// register when its item leaves the input register and can transfer out from there.
// Synchronous active-high reset loads the register defaults, sync hunting and
// zero history. A held result only stalls the input when the waiting item would
// itself give a result; sync and front bytes keep flowing.
module wall_follow_pd_drive (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_opcode,
   input  logic [7:0]                         req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [7:0]                         rsp_left_duty,
   output logic [7:0]                         rsp_right_duty,
   output logic                               rsp_left_forward,
   output logic                               rsp_right_forward,
   output logic                               rsp_wall_seen,
   input  logic                               csr_we,
   input  logic [wfpd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [7:0]                         csr_wdata
);
   import wfpd_pkg::*;

   // Configuration registers
   cfg_type cfg_ff;

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic       in_op_ff;
   logic [7:0] in_byte_ff;

   // Frame and history state
   phase_type               phase_ff, phase_in;
   logic [7:0]              front_ff, front_in;
   logic signed [ERR_W-1:0] lprev_ff, lprev_in;
   logic signed [ERR_W-1:0] rprev_ff, rprev_in;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_left_ff, rsp_right_ff;
   logic       rsp_lfwd_ff, rsp_rfwd_ff, rsp_wall_ff;

   // Datapath
   logic signed [ERR_W-1:0] e_front, e_rear, e_left, e_right;
   logic [7:0]              pl_duty, pr_duty;
   logic [7:0]              res_left, res_right;
   logic                    res_fwd, res_wall;
   logic                    produce;
   logic                    out_free;
   logic                    in_move;
   logic                    req_take;
   logic                    no_wall;
   logic                    turn;

   // ---------------------------------------------------------------
   // Configuration writes
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain       <= RST_PROP_GAIN;
         cfg_ff.deriv_gain      <= RST_DERIV_GAIN;
         cfg_ff.target_distance <= RST_TARGET_DISTANCE;
         cfg_ff.base_duty       <= RST_BASE_DUTY;
         cfg_ff.duty_max        <= RST_DUTY_MAX;
         cfg_ff.duty_min        <= RST_DUTY_MIN;
         cfg_ff.wall_threshold  <= RST_WALL_THRESHOLD;
         cfg_ff.turn_duty       <= RST_TURN_DUTY;
      end else if (csr_we) begin
         case (csr_index)
            REG_PROP_GAIN:       cfg_ff.prop_gain       <= csr_wdata;
            REG_DERIV_GAIN:      cfg_ff.deriv_gain      <= csr_wdata;
            REG_TARGET_DISTANCE: cfg_ff.target_distance <= csr_wdata;
            REG_BASE_DUTY:       cfg_ff.base_duty       <= csr_wdata;
            REG_DUTY_MAX:        cfg_ff.duty_max        <= csr_wdata;
            REG_DUTY_MIN:        cfg_ff.duty_min        <= csr_wdata;
            REG_WALL_THRESHOLD:  cfg_ff.wall_threshold  <= csr_wdata;
            REG_TURN_DUTY:       cfg_ff.turn_duty       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Handshake: the input register drains when the result register can
   // take its result, or when it gives no result at all.
   // ---------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign in_move   = in_valid_ff && (out_free || !produce);
   assign req_stall = in_valid_ff && !in_move;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (in_move) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_opcode;
         in_byte_ff <= req_rx_byte;
      end
   end

   // ---------------------------------------------------------------
   // Wall errors: invert readings (255 - x is ~x), subtract target
   // ---------------------------------------------------------------
   assign e_front = $signed({3'b000, ~front_ff}) - $signed({3'b000, cfg_ff.target_distance});
   assign e_rear  = $signed({3'b000, ~in_byte_ff})
                  - $signed({3'b000, cfg_ff.target_distance});
   assign e_left  = (e_front <<< 1) - e_rear;
   assign e_right = -e_left;

   wfpd_side u_left_side (
      .err      (e_left),
      .err_prev (lprev_ff),
      .cfg      (cfg_ff),
      .duty     (pl_duty)
   );

   wfpd_side u_right_side (
      .err      (e_right),
      .err_prev (rprev_ff),
      .cfg      (cfg_ff),
      .duty     (pr_duty)
   );

   assign no_wall = (front_ff < cfg_ff.wall_threshold) || (in_byte_ff < cfg_ff.wall_threshold);

   // Both sides running hot: force the turn
   assign turn = ({1'b0, pl_duty} > ({1'b0, cfg_ff.base_duty} + TURN_MARGIN))
              && ({1'b0, pr_duty} > ({1'b0, cfg_ff.base_duty} + TURN_MARGIN));

   // ---------------------------------------------------------------
   // Framing sequencer: next state and the result of the held item
   // ---------------------------------------------------------------
   always_comb begin
      phase_in  = phase_ff;
      front_in  = front_ff;
      lprev_in  = lprev_ff;
      rprev_in  = rprev_ff;
      produce   = 1'b0;
      res_left  = '0;
      res_right = '0;
      res_fwd   = 1'b0;
      res_wall  = 1'b0;
      if (in_op_ff == OP_STOP) begin
         // Stop: zero result, drop history and sync
         produce  = 1'b1;
         phase_in = PH_SYNC;
         lprev_in = '0;
         rprev_in = '0;
      end else begin
         case (phase_ff)
            PH_FRONT: begin
               front_in = in_byte_ff;
               phase_in = PH_REAR;
            end
            PH_REAR: begin
               phase_in = PH_SYNC;
               produce  = 1'b1;
               res_fwd  = 1'b1;
               if (no_wall) begin
                  // Straight ahead, history untouched
                  res_left  = cfg_ff.base_duty;
                  res_right = cfg_ff.base_duty;
               end else begin
                  res_wall = 1'b1;
                  lprev_in = e_left;
                  rprev_in = e_right;
                  if (turn) begin
                     res_left  = cfg_ff.turn_duty;
                     res_right = cfg_ff.base_duty;
                  end else begin
                     res_left  = pl_duty;
                     res_right = pr_duty;
                  end
               end
            end
            default: begin
               // Hunt for the sync byte
               phase_in = (in_byte_ff == SYNC_BYTE) ? PH_FRONT : PH_SYNC;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC;
         lprev_ff <= '0;
         rprev_ff <= '0;
      end else if (in_move) begin
         phase_ff <= phase_in;
         lprev_ff <= lprev_in;
         rprev_ff <= rprev_in;
      end
   end

   // Front reading needs no reset: it is always written before the rear byte
   always_ff @(posedge clock) begin
      if (in_move) begin
         front_ff <= front_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register: load on a producing move, hold while stalled
   // ---------------------------------------------------------------
   always_comb begin
      if (in_move && produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_stall) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_move && produce) begin
         rsp_left_ff  <= res_left;
         rsp_right_ff <= res_right;
         rsp_lfwd_ff  <= res_fwd;
         rsp_rfwd_ff  <= res_fwd;
         rsp_wall_ff  <= res_wall;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_duty     = rsp_left_ff;
   assign rsp_right_duty    = rsp_right_ff;
   assign rsp_left_forward  = rsp_lfwd_ff;
   assign rsp_right_forward = rsp_rfwd_ff;
   assign rsp_wall_seen     = rsp_wall_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_stop_result: assert property (@(posedge clock) disable iff (reset)
      (in_move && in_op_ff == OP_STOP) |=>
         (rsp_valid_ff && rsp_left_ff == 8'd0 && rsp_right_ff == 8'd0 && !rsp_wall_ff))
      else $error("stop item did not give a zero result");

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (in_move && in_op_ff == OP_STOP) |=>
         (phase_ff == PH_SYNC && lprev_ff == '0 && rprev_ff == '0))
      else $error("stop item did not clear sync and history");

   a_mirror_hist: assert property (@(posedge clock) disable iff (reset)
      rprev_ff == -lprev_ff)
      else $error("side histories lost their mirror relation");

   a_wall_fwd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_wall_ff) |-> (rsp_lfwd_ff && rsp_rfwd_ff))
      else $error("PD result without forward drive");

   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && produce && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a held result in the way");

endmodule

// ----- test/wall_follow_pd_drive_checker.sv -----
// Result checker for the wall-follow PD drive: tracks framing, history and registers, scores duties.
module wall_follow_pd_drive_checker
   import wfpd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic                   req_opcode,
   input  logic [7:0]             req_rx_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [7:0]             rsp_left_duty,
   input  logic [7:0]             rsp_right_duty,
   input  logic                   rsp_left_forward,
   input  logic                   rsp_right_forward,
   input  logic                   rsp_wall_seen,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata,
   output int                     mismatch_count,
   output int                     pending_duties
);

   typedef struct {
      logic [7:0] left_duty;
      logic [7:0] right_duty;
      logic       left_forward;
      logic       right_forward;
      logic       wall_seen;
   } drive_cmd_type;

   cfg_type                  regs;
   phase_type                frame_phase;
   logic [7:0]               front_reading;
   logic signed [ERR_W-1:0]  left_err_hist;
   logic signed [ERR_W-1:0]  right_err_hist;
   drive_cmd_type            expected_duties[$];
   int                       bad_fields = 0;

   assign mismatch_count = bad_fields;

   function automatic int clamp_duty(input int level);
      if (level > int'(regs.duty_max)) return int'(regs.duty_max);
      if (level < int'(regs.duty_min)) return int'(regs.duty_min);
      return level;
   endfunction

   // Advance the framing and PD history by one byte or stop; return 1 when a duty command results.
   function automatic bit predict_drive(input logic op, input logic [7:0] rx,
                                        output drive_cmd_type cmd);
      int e_front;
      int e_rear;
      int e_left;
      int e_right;
      int u_left;
      int u_right;
      int left_cmd;
      int right_cmd;
      int turn_level;
      cmd = '{8'd0, 8'd0, 1'b0, 1'b0, 1'b0};
      if (op == OP_STOP) begin
         frame_phase    = PH_SYNC;
         left_err_hist  = '0;
         right_err_hist = '0;
         return 1'b1;
      end
      case (frame_phase)
         PH_FRONT: begin
            front_reading = rx;
            frame_phase   = PH_REAR;
            return 1'b0;
         end
         PH_REAR: begin
            frame_phase = PH_SYNC;
         end
         default: begin
            frame_phase = (rx == SYNC_BYTE) ? PH_FRONT : PH_SYNC;
            return 1'b0;
         end
      endcase

      if (front_reading < regs.wall_threshold || rx < regs.wall_threshold) begin
         cmd = '{regs.base_duty, regs.base_duty, 1'b1, 1'b1, 1'b0};
         return 1'b1;
      end

      e_front = (255 - int'(front_reading)) - int'(regs.target_distance);
      e_rear  = (255 - int'(rx)) - int'(regs.target_distance);
      e_left  = 2 * e_front - e_rear;
      e_right = -e_left;

      // arithmetic shift floors toward minus infinity
      u_left  = ((2 * e_left * int'(regs.prop_gain)) >>> 6)
              + (((e_left - int'(left_err_hist)) * int'(regs.deriv_gain)) >>> 6);
      u_right = ((2 * e_right * int'(regs.prop_gain)) >>> 6)
              + (((e_right - int'(right_err_hist)) * int'(regs.deriv_gain)) >>> 6);

      left_err_hist  = ERR_W'(e_left);
      right_err_hist = ERR_W'(e_right);

      left_cmd   = clamp_duty(u_left + int'(regs.base_duty));
      right_cmd  = clamp_duty(u_right + int'(regs.base_duty));
      turn_level = int'(regs.base_duty) + int'(TURN_MARGIN);
      if (right_cmd > turn_level && left_cmd > turn_level) begin
         right_cmd = int'(regs.base_duty);
         left_cmd  = int'(regs.turn_duty);
      end
      cmd = '{8'(left_cmd), 8'(right_cmd), 1'b1, 1'b1, 1'b1};
      return 1'b1;
   endfunction

   task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         bad_fields++;
      end
   endtask

   always @(posedge clock) begin : score
      drive_cmd_type want;
      drive_cmd_type next_cmd;
      if (reset) begin
         regs = '{RST_PROP_GAIN, RST_DERIV_GAIN, RST_TARGET_DISTANCE, RST_BASE_DUTY,
                  RST_DUTY_MAX, RST_DUTY_MIN, RST_WALL_THRESHOLD, RST_TURN_DUTY};
         frame_phase    = PH_SYNC;
         front_reading  = '0;
         left_err_hist  = '0;
         right_err_hist = '0;
         expected_duties.delete();
      end else begin
         // score before predicting: a result never belongs to an item taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_duties.size() == 0) begin
               $display("%0t: unexpected duty command L=%0d R=%0d", $time,
                        rsp_left_duty, rsp_right_duty);
               bad_fields++;
            end else begin
               want = expected_duties.pop_front();
               check_field("left_duty", want.left_duty, rsp_left_duty);
               check_field("right_duty", want.right_duty, rsp_right_duty);
               check_field("left_forward", 8'(want.left_forward), 8'(rsp_left_forward));
               check_field("right_forward", 8'(want.right_forward), 8'(rsp_right_forward));
               check_field("wall_seen", 8'(want.wall_seen), 8'(rsp_wall_seen));
            end
         end
         if (req_valid && !req_stall) begin
            if (predict_drive(req_opcode, req_rx_byte, next_cmd))
               expected_duties.push_back(next_cmd);
         end
         if (csr_we) begin
            case (csr_index)
               REG_PROP_GAIN:       regs.prop_gain       = csr_wdata;
               REG_DERIV_GAIN:      regs.deriv_gain      = csr_wdata;
               REG_TARGET_DISTANCE: regs.target_distance = csr_wdata;
               REG_BASE_DUTY:       regs.base_duty       = csr_wdata;
               REG_DUTY_MAX:        regs.duty_max        = csr_wdata;
               REG_DUTY_MIN:        regs.duty_min        = csr_wdata;
               REG_WALL_THRESHOLD:  regs.wall_threshold  = csr_wdata;
               REG_TURN_DUTY:       regs.turn_duty       = csr_wdata;
               default: ;
            endcase
         end
      end
      pending_duties <= expected_duties.size();
   end

endmodule

// ----- test/wall_follow_pd_drive_tb.sv -----
// Testbench top for the wall-follow PD drive: clock, reset, stimulus, register phases, verdict.
module wall_follow_pd_drive_tb;
   import wfpd_pkg::*;

   localparam int RESET_CYCLES    = 9;
   localparam int IDLE_PERCENT    = 31;
   localparam int ITEMS_PER_PHASE = 140;
   localparam int CONFIG_PHASES   = 8;
   localparam int CALM_PHASE      = 5;
   // a result is registered once its item leaves the input register; give the pipe a little extra
   localparam int SETTLE_CYCLES   = 4;
   localparam int QUIET_LIMIT     = 3000;

   logic                   clock             = 1'b0;
   logic                   reset             = 1'b1;
   logic                   req_valid         = 1'b0;
   logic                   req_stall;
   logic                   req_opcode        = OP_BYTE;
   logic [7:0]             req_rx_byte       = 8'd0;
   logic                   rsp_valid;
   logic                   rsp_stall         = 1'b0;
   logic [7:0]             rsp_left_duty;
   logic [7:0]             rsp_right_duty;
   logic                   rsp_left_forward;
   logic                   rsp_right_forward;
   logic                   rsp_wall_seen;
   logic                   csr_we            = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index         = REG_PROP_GAIN;
   logic [7:0]             csr_wdata         = 8'd0;

   int                     mismatch_count;
   int                     pending_duties;
   int                     quiet_cycles      = 0;
   // no idling on either side while calm is high
   logic                   calm              = 1'b0;
   // threshold currently loaded, used to aim readings at the wall boundary
   logic [7:0]             wall_level        = RST_WALL_THRESHOLD;

   always #5 clock = ~clock;

   wall_follow_pd_drive DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_left_duty     (rsp_left_duty),
      .rsp_right_duty    (rsp_right_duty),
      .rsp_left_forward  (rsp_left_forward),
      .rsp_right_forward (rsp_right_forward),
      .rsp_wall_seen     (rsp_wall_seen),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   wall_follow_pd_drive_checker duty_scoreboard (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_left_duty     (rsp_left_duty),
      .rsp_right_duty    (rsp_right_duty),
      .rsp_left_forward  (rsp_left_forward),
      .rsp_right_forward (rsp_right_forward),
      .rsp_wall_seen     (rsp_wall_seen),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .pending_duties    (pending_duties)
   );

   // Back-pressure on the result side: random stalls, none during the calm stretch.
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
   end

   // Watchdog: count cycles with no transfer on any port; a hang ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one item and hold it until the transfer. Valid stays high on return so
   // back-to-back items never lower and raise it in one step; the next call drops it
   // only when it decides to idle.
   task automatic send_item(input logic op, input logic [7:0] rx);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_rx_byte <= rx;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every duty command is back and the pipe has drained.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_duties == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_settings(input cfg_type s);
      write_reg(REG_PROP_GAIN, s.prop_gain);
      write_reg(REG_DERIV_GAIN, s.deriv_gain);
      write_reg(REG_TARGET_DISTANCE, s.target_distance);
      write_reg(REG_BASE_DUTY, s.base_duty);
      write_reg(REG_DUTY_MAX, s.duty_max);
      write_reg(REG_DUTY_MIN, s.duty_min);
      write_reg(REG_WALL_THRESHOLD, s.wall_threshold);
      write_reg(REG_TURN_DUTY, s.turn_duty);
      csr_we     <= 1'b0;
      wall_level  = s.wall_threshold;
   endtask

   // Register sets per phase: all zero, all ones, a clamp floor above base+10 so the
   // turn fires, an inverted clamp window, then random sets.
   function automatic cfg_type pick_settings(input int phase_no);
      cfg_type s;
      case (phase_no)
         0: s = '0;
         1: s = '1;
         2: s = '{prop_gain: 8'd255, deriv_gain: 8'd255, target_distance: 8'd128,
                  base_duty: 8'd90, duty_max: 8'd255, duty_min: 8'd150,
                  wall_threshold: 8'd65, turn_duty: 8'd17};
         3: s = '{prop_gain: 8'd64, deriv_gain: 8'd32, target_distance: 8'd110,
                  base_duty: 8'd90, duty_max: 8'd50, duty_min: 8'd200,
                  wall_threshold: 8'd40, turn_duty: 8'd200};
         default: s = cfg_type'({$urandom, $urandom});
      endcase
      return s;
   endfunction

   // Wall readings: rails, the threshold boundary, or anything.
   function automatic logic [7:0] pick_reading();
      int level;
      case ($urandom_range(5))
         0: return 8'h00;
         1: return 8'hFF;
         2: begin
            level = int'(wall_level) + int'($urandom_range(2)) - 1;
            if (level < 0) level = 0;
            if (level > 255) level = 255;
            return 8'(level);
         end
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Mostly whole frames with random readings; the rest stops, hunting noise and
   // frames cut short by a stop. Noise is dropped by the block and is not counted.
   task automatic random_traffic(input int count);
      int done;
      int pick;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            send_item(OP_BYTE, SYNC_BYTE);
            send_item(OP_BYTE, pick_reading());
            send_item(OP_BYTE, pick_reading());
            done += 3;
         end else if (pick < 83) begin
            send_item(OP_STOP, 8'($urandom_range(255)));
            done++;
         end else if (pick < 91) begin
            send_item(OP_BYTE, 8'($urandom_range(1, 255)));
         end else begin
            send_item(OP_BYTE, SYNC_BYTE);
            done++;
            if ($urandom_range(1)) begin
               send_item(OP_BYTE, pick_reading());
               done++;
            end
            send_item(OP_STOP, 8'($urandom_range(255)));
            done++;
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames with the reset register values.
      send_item(OP_STOP, 8'hA5);           // stop before any sync
      send_item(OP_BYTE, 8'h5A);           // nonzero byte while hunting: dropped
      send_item(OP_BYTE, SYNC_BYTE);       // both readings at the far rail
      send_item(OP_BYTE, 8'hFF);
      send_item(OP_BYTE, 8'hFF);
      send_item(OP_BYTE, SYNC_BYTE);       // zero taken as front data, no wall
      send_item(OP_BYTE, 8'h00);
      send_item(OP_BYTE, 8'd200);
      send_item(OP_BYTE, SYNC_BYTE);       // rear one below threshold
      send_item(OP_BYTE, 8'd200);
      send_item(OP_BYTE, 8'd64);
      send_item(OP_BYTE, SYNC_BYTE);       // both right at threshold, history carried
      send_item(OP_BYTE, 8'd65);
      send_item(OP_BYTE, 8'd65);
      send_item(OP_BYTE, SYNC_BYTE);       // stop cuts the frame, history cleared
      send_item(OP_BYTE, 8'd100);
      send_item(OP_STOP, 8'h00);
      send_item(OP_BYTE, 8'd100);          // hunting again: dropped
      send_item(OP_BYTE, SYNC_BYTE);       // largest error swing
      send_item(OP_BYTE, 8'hFF);
      send_item(OP_BYTE, 8'd65);
      send_item(OP_BYTE, SYNC_BYTE);
      send_item(OP_BYTE, 8'd65);
      send_item(OP_BYTE, 8'hFF);
      send_item(OP_STOP, 8'hFF);
      random_traffic(ITEMS_PER_PHASE);

      // Register phases: each starts with the block idle and writes every register.
      for (int phase_no = 0; phase_no < CONFIG_PHASES; phase_no++) begin
         settle();
         load_settings(pick_settings(phase_no));
         calm <= (phase_no == CALM_PHASE);
         random_traffic(ITEMS_PER_PHASE);
      end

      settle();
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/wfpd_pkg.sv
sv/wfpd_side.sv
sv/wall_follow_pd_drive.sv
test/wall_follow_pd_drive_checker.sv
test/wall_follow_pd_drive_tb.sv
